// ----- hw/rtl/b64le_pkg.sv -----
// Shared types, character codes and the base64 alphabet for the line-wrapped encoder.
package b64le_pkg;

    // ASCII codes used around the symbols
    localparam logic [7:0] CH_CR  = 8'd13;
    localparam logic [7:0] CH_LF  = 8'd10;
    localparam logic [7:0] CH_PAD = 8'd61;

    // Job queue geometry
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // One job: four characters, then an optional line-wrap CR LF, then an optional final CR LF
    typedef struct packed {
        logic [3:0][7:0] chars;
        logic            wrap;
        logic            fin;
    } job_t;

    // Map a 6-bit value to its base64 alphabet character
    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] ch;
        if (v < 6'd26)
        begin
            ch = 8'd65 + {2'b00, v};
        end
        else if (v < 6'd52)
        begin
            ch = 8'd71 + {2'b00, v};
        end
        else if (v < 6'd62)
        begin
            ch = {2'b00, v} - 8'd4;
        end
        else if (v == 6'd62)
        begin
            ch = 8'd43;
        end
        else
        begin
            ch = 8'd47;
        end
        return ch;
    endfunction

endpackage

// ----- hw/rtl/b64le_front.sv -----
// Front end: gathers bytes into groups of three and builds character jobs.
module b64le_front
    import b64le_pkg::*;
#(
    parameter int GROUPS_PER_LINE = 19
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    input  logic       q_full,
    output logic       job_push,
    output job_t       job
);

    localparam int GW = $clog2(GROUPS_PER_LINE + 1);
    localparam logic [GW-1:0] GLIMIT = GW'(GROUPS_PER_LINE);

    localparam logic [1:0] PH_NONE = 2'd0;
    localparam logic [1:0] PH_ONE  = 2'd1;
    localparam logic [1:0] PH_TWO  = 2'd2;

    logic [15:0]   held_reg, held_next;
    logic [1:0]    phase_reg, phase_next;
    logic [GW-1:0] groups_reg, groups_next;
    logic [GW-1:0] group_inc;
    logic [7:0]    b0, b1;
    logic          accept;
    logic          wrap;

    assign accept    = push && !q_full;
    assign b0        = held_reg[15:8];
    assign b1        = held_reg[7:0];
    assign group_inc = groups_reg + 1'b1;
    assign wrap      = (group_inc >= GLIMIT);

    // Classify the byte and form a job when a group or the body ends
    always_comb
    begin
        held_next   = held_reg;
        phase_next  = phase_reg;
        groups_next = groups_reg;
        job_push    = 1'b0;
        job.chars   = '0;
        job.wrap    = 1'b0;
        job.fin     = last_byte;
        case (phase_reg)
            PH_NONE:
            begin
                if (last_byte)
                begin
                    job_push     = accept;
                    job.chars[0] = b64_char(data_byte[7:2]);
                    job.chars[1] = b64_char({data_byte[1:0], 4'b0000});
                    job.chars[2] = CH_PAD;
                    job.chars[3] = CH_PAD;
                    held_next    = '0;
                    groups_next  = '0;
                end
                else
                begin
                    held_next  = {data_byte, 8'h00};
                    phase_next = PH_ONE;
                end
            end
            PH_ONE:
            begin
                if (last_byte)
                begin
                    job_push     = accept;
                    job.chars[0] = b64_char(b0[7:2]);
                    job.chars[1] = b64_char({b0[1:0], data_byte[7:4]});
                    job.chars[2] = b64_char({data_byte[3:0], 2'b00});
                    job.chars[3] = CH_PAD;
                    held_next    = '0;
                    phase_next   = PH_NONE;
                    groups_next  = '0;
                end
                else
                begin
                    held_next  = {b0, data_byte};
                    phase_next = PH_TWO;
                end
            end
            default:
            begin
                job_push     = accept;
                job.chars[0] = b64_char(b0[7:2]);
                job.chars[1] = b64_char({b0[1:0], b1[7:4]});
                job.chars[2] = b64_char({b1[3:0], data_byte[7:6]});
                job.chars[3] = b64_char(data_byte[5:0]);
                job.wrap     = wrap;
                held_next    = '0;
                phase_next   = PH_NONE;
                groups_next  = (wrap || last_byte) ? '0 : group_inc;
            end
        endcase
    end

    // Advance group state on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg   <= '0;
            phase_reg  <= PH_NONE;
            groups_reg <= '0;
        end
        else if (accept)
        begin
            held_reg   <= held_next;
            phase_reg  <= phase_next;
            groups_reg <= groups_next;
        end
    end

endmodule

// ----- hw/rtl/b64le_queue.sv -----
// Short job queue between the front end and the character serializer.
module b64le_queue
    import b64le_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  job_t wr_job,
    output logic q_full,
    input  logic rd_en,
    output logic q_empty,
    output job_t head
);

    job_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_wr;
    logic              do_rd;

    assign q_full  = (count_reg == QCNT_W'(QDEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign head    = mem[rd_ptr_reg];

    // Store incoming jobs
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_job;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- hw/rtl/b64le_back.sv -----
// Back end: walks each job into the output register, one character per cycle while the register is free or popped.
module b64le_back
    import b64le_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    input  job_t       head,
    output logic       q_pop,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_char,
    output logic       out_last
);

    localparam logic [2:0] ST_C0  = 3'd0;
    localparam logic [2:0] ST_C1  = 3'd1;
    localparam logic [2:0] ST_C2  = 3'd2;
    localparam logic [2:0] ST_C3  = 3'd3;
    localparam logic [2:0] ST_CR1 = 3'd4;
    localparam logic [2:0] ST_LF1 = 3'd5;
    localparam logic [2:0] ST_CR2 = 3'd6;
    localparam logic [2:0] ST_LF2 = 3'd7;

    logic [2:0] step_reg, step_next;
    logic       valid_reg;
    logic [7:0] char_reg;
    logic       last_reg;
    logic [7:0] cur_char;
    logic       cur_last;
    logic       advance;
    logic       done;

    assign advance  = !q_empty && (!valid_reg || pop);
    assign q_pop    = advance && done;
    assign empty    = !valid_reg;
    assign out_char = char_reg;
    assign out_last = last_reg;

    // Select the character for this step and the step that follows
    always_comb
    begin
        cur_char  = head.chars[step_reg[1:0]];
        cur_last  = 1'b0;
        done      = 1'b0;
        step_next = step_reg + 1'b1;
        case (step_reg)
            ST_C0, ST_C1, ST_C2:
            begin
                step_next = step_reg + 1'b1;
            end
            ST_C3:
            begin
                if (head.wrap)
                begin
                    step_next = ST_CR1;
                end
                else if (head.fin)
                begin
                    step_next = ST_CR2;
                end
                else
                begin
                    step_next = ST_C0;
                    done      = 1'b1;
                end
            end
            ST_CR1:
            begin
                cur_char  = CH_CR;
                step_next = ST_LF1;
            end
            ST_LF1:
            begin
                cur_char = CH_LF;
                if (head.fin)
                begin
                    step_next = ST_CR2;
                end
                else
                begin
                    step_next = ST_C0;
                    done      = 1'b1;
                end
            end
            ST_CR2:
            begin
                cur_char  = CH_CR;
                step_next = ST_LF2;
            end
            ST_LF2:
            begin
                cur_char  = CH_LF;
                cur_last  = 1'b1;
                step_next = ST_C0;
                done      = 1'b1;
            end
            default:
            begin
                step_next = ST_C0;
                done      = 1'b1;
            end
        endcase
    end

    // Advance the step and track output occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= ST_C0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                step_reg  <= step_next;
                valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Load the output character
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            char_reg <= cur_char;
            last_reg <= cur_last;
        end
    end

endmodule

// ----- hw/rtl/base64_line_wrapped_encoder.sv -----
// Top level of the streaming base64 encoder with MIME line wrapping.
// Bytes enter one per cycle while the job queue has room; every third byte, or
// the byte marked last, becomes a job of four characters plus optional CR LF pairs.
// Characters leave one per cycle while pop is held; the output serializer emits
// four characters per three-byte group, six when the group ends a line, and up to
// eight for the final group of a body.
// The byte that completes a group is written as a job into the queue, and its first
// character is then loaded into the output register once the serializer reaches it.
// A body always ends in CR LF, with out_last high on that final LF.
module base64_line_wrapped_encoder
    import b64le_pkg::*;
#(
    parameter int GROUPS_PER_LINE = 19
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_char,
    output logic       out_last
);

    logic job_push;
    job_t job;
    logic q_empty;
    logic q_pop;
    job_t head;

    // Gather bytes into jobs
    b64le_front #(
        .GROUPS_PER_LINE(GROUPS_PER_LINE)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .data_byte(data_byte),
        .last_byte(last_byte),
        .q_full   (full),
        .job_push (job_push),
        .job      (job)
    );

    // Buffer jobs between the two sides
    b64le_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (job_push),
        .wr_job (job),
        .q_full (full),
        .rd_en  (q_pop),
        .q_empty(q_empty),
        .head   (head)
    );

    // Serialize characters
    b64le_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .head    (head),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .out_char(out_char),
        .out_last(out_last)
    );

endmodule

// ----- hw/rtl/b64le_checker.sv -----
// Port-level checks for the line-wrapped base64 encoder, bound to the top level.
module b64le_checker
    import b64le_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       push,
    input logic       full,
    input logic [7:0] data_byte,
    input logic       last_byte,
    input logic       empty,
    input logic       pop,
    input logic [7:0] out_char,
    input logic       out_last
);

    logic shown_ok;

    // Every shown character belongs to the output alphabet
    assign shown_ok = (out_char >= 8'd65 && out_char <= 8'd90) ||
                      (out_char >= 8'd97 && out_char <= 8'd122) ||
                      (out_char >= 8'd48 && out_char <= 8'd57) ||
                      (out_char == 8'd43) || (out_char == 8'd47) ||
                      (out_char == CH_PAD) || (out_char == CH_CR) ||
                      (out_char == CH_LF);

    // Shown characters are legal
    assert property (@(posedge clk) disable iff (!rst_n) !empty |-> shown_ok)
        else $error("illegal output character");

    // The body end mark sits on a line feed
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_last) |-> (out_char == CH_LF))
        else $error("end mark not on LF");

    // A carriage return shown is never itself the end of the body
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_char == CH_CR) |-> !out_last)
        else $error("end mark on CR");

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_char) && $stable(out_last)))
        else $error("stalled result changed");

    // Handshake flags and offered items are always known
    assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({full, empty}) && (!push || !$isunknown({data_byte, last_byte})))
        else $error("unknown handshake or offered item");

endmodule

bind base64_line_wrapped_encoder b64le_checker u_b64le_checker (.*);
